FILE: hw/rtl/vsp_pkg.sv
package vsp_pkg;

  localparam int BONE_COUNT_DEF = 32;
  localparam int MAT_WORDS      = 12;

  localparam logic OP_VERTEX = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic [2:0] REG_SKIN_ENABLE  = 3'd0;
  localparam logic [2:0] REG_LIGHT_ENABLE = 3'd1;
  localparam logic [2:0] REG_FOCAL_LENGTH = 3'd2;
  localparam logic [2:0] REG_NEAR_DEPTH   = 3'd3;
  localparam logic [2:0] REG_COS_YAW      = 3'd4;
  localparam logic [2:0] REG_SIN_YAW      = 3'd5;
  localparam logic [2:0] REG_COS_PITCH    = 3'd6;
  localparam logic [2:0] REG_SIN_PITCH    = 3'd7;

  localparam logic [30:0]        FOCAL_RST     = 31'd25427968;
  localparam logic [30:0]        NEAR_RST      = 31'd19661;
  localparam logic signed [17:0] COS_YAW_RST   = 18'sd54087;
  localparam logic signed [17:0] SIN_YAW_RST   = 18'sd37002;
  localparam logic signed [17:0] COS_PITCH_RST = 18'sd63498;
  localparam logic signed [17:0] SIN_PITCH_RST = 18'sd16214;

  localparam logic signed [17:0] LIGHT_LX      = 18'sd19661;
  localparam logic signed [17:0] LIGHT_LY      = 18'sd58982;
  localparam logic signed [17:0] LIGHT_LZ      = 18'sd19661;
  localparam logic signed [17:0] LIGHT_GAIN    = 18'sd45875;
  localparam logic signed [38:0] LIGHT_AMBIENT = 39'sd26214;

  localparam logic [30:0] INV_MAX = 31'h7fffffff;

  typedef struct packed {
    logic               skin_en;
    logic               light_en;
    logic [30:0]        focal;
    logic [30:0]        near_d;
    logic signed [17:0] cos_yaw;
    logic signed [17:0] sin_yaw;
    logic signed [17:0] cos_pitch;
    logic signed [17:0] sin_pitch;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] rxs;
    logic signed [31:0] rys;
    logic signed [31:0] depth;
    logic               vis;
    logic               inv_sat;
    logic [7:0]         shade;
  } proj_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

FILE: hw/rtl/vertex_skin_project_light.sv
// Vertex items pass vsp_xform, vsp_recip and a product register to the output.
// Throughput: one item per cycle while in_stall is low; a load item gives no result.
// The depth reciprocal is a 31-stage restoring divider, one quotient bit a stage.
// Reset clears all valid bits and loads the register defaults.
// The bone palette is not cleared: a word reads undefined until written.
module vertex_skin_project_light #(
  parameter int BONE_COUNT = vsp_pkg::BONE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_nrm_x,
  input  logic signed [31:0] in_nrm_y,
  input  logic signed [31:0] in_nrm_z,
  input  logic [4:0]         in_bone,
  input  logic [3:0]         in_matrix_word,
  input  logic signed [31:0] in_matrix_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_screen_x,
  output logic signed [31:0] out_screen_y,
  output logic [30:0]        out_inv_depth,
  output logic signed [31:0] out_view_depth,
  output logic               out_visible,
  output logic [7:0]         out_brightness
);

  vsp_pkg::cfg_t cfg_r;
  logic          cfg_wr;
  logic [2:0]    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.skin_en   <= 1'b0;
      cfg_r.light_en  <= 1'b0;
      cfg_r.focal     <= vsp_pkg::FOCAL_RST;
      cfg_r.near_d    <= vsp_pkg::NEAR_RST;
      cfg_r.cos_yaw   <= vsp_pkg::COS_YAW_RST;
      cfg_r.sin_yaw   <= vsp_pkg::SIN_YAW_RST;
      cfg_r.cos_pitch <= vsp_pkg::COS_PITCH_RST;
      cfg_r.sin_pitch <= vsp_pkg::SIN_PITCH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        vsp_pkg::REG_SKIN_ENABLE:  cfg_r.skin_en   <= cfg_pwdata[0];
        vsp_pkg::REG_LIGHT_ENABLE: cfg_r.light_en  <= cfg_pwdata[0];
        vsp_pkg::REG_FOCAL_LENGTH: cfg_r.focal     <= cfg_pwdata[30:0];
        vsp_pkg::REG_NEAR_DEPTH:   cfg_r.near_d    <= cfg_pwdata[30:0];
        vsp_pkg::REG_COS_YAW:      cfg_r.cos_yaw   <= $signed(cfg_pwdata[17:0]);
        vsp_pkg::REG_SIN_YAW:      cfg_r.sin_yaw   <= $signed(cfg_pwdata[17:0]);
        vsp_pkg::REG_COS_PITCH:    cfg_r.cos_pitch <= $signed(cfg_pwdata[17:0]);
        vsp_pkg::REG_SIN_PITCH:    cfg_r.sin_pitch <= $signed(cfg_pwdata[17:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      vsp_pkg::REG_SKIN_ENABLE:  cfg_prdata = {31'd0, cfg_r.skin_en};
      vsp_pkg::REG_LIGHT_ENABLE: cfg_prdata = {31'd0, cfg_r.light_en};
      vsp_pkg::REG_FOCAL_LENGTH: cfg_prdata = {1'b0, cfg_r.focal};
      vsp_pkg::REG_NEAR_DEPTH:   cfg_prdata = {1'b0, cfg_r.near_d};
      vsp_pkg::REG_COS_YAW:      cfg_prdata = {14'd0, cfg_r.cos_yaw};
      vsp_pkg::REG_SIN_YAW:      cfg_prdata = {14'd0, cfg_r.sin_yaw};
      vsp_pkg::REG_COS_PITCH:    cfg_prdata = {14'd0, cfg_r.cos_pitch};
      vsp_pkg::REG_SIN_PITCH:    cfg_prdata = {14'd0, cfg_r.sin_pitch};
      default:                   cfg_prdata = '0;
    endcase
  end

  logic           xf_valid, xf_stall;
  vsp_pkg::proj_t xf_data;
  logic           rc_valid, rc_stall;
  vsp_pkg::proj_t rc_data;
  logic [30:0]    rc_inv;

  vsp_xform #(.BONE_COUNT(BONE_COUNT)) u_xform (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_nrm_x        (in_nrm_x),
    .in_nrm_y        (in_nrm_y),
    .in_nrm_z        (in_nrm_z),
    .in_bone         (in_bone),
    .in_matrix_word  (in_matrix_word),
    .in_matrix_value (in_matrix_value),
    .dn_valid        (xf_valid),
    .dn_stall        (xf_stall),
    .dn_data         (xf_data)
  );

  vsp_recip u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (xf_valid),
    .up_stall (xf_stall),
    .up_data  (xf_data),
    .dn_valid (rc_valid),
    .dn_stall (rc_stall),
    .dn_data  (rc_data),
    .dn_inv   (rc_inv)
  );

  logic               en_o, en_p;
  logic               vp_r, out_valid_r;
  logic signed [63:0] px_r, py_r;
  logic [30:0]        invp_r;
  vsp_pkg::proj_t     plp_r;

  logic signed [31:0] out_screen_x_r, out_screen_y_r, out_view_depth_r;
  logic [30:0]        out_inv_depth_r;
  logic               out_visible_r;
  logic [7:0]         out_brightness_r;

  assign en_o     = !out_valid_r || !out_stall;
  assign en_p     = !vp_r || en_o;
  assign rc_stall = !en_p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_p) vp_r <= rc_valid;
      if (en_o) out_valid_r <= vp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_p) begin
      px_r   <= 64'(rc_data.rxs) * 64'($signed({1'b0, rc_inv}));
      py_r   <= 64'(rc_data.rys) * 64'($signed({1'b0, rc_inv}));
      invp_r <= rc_inv;
      plp_r  <= rc_data;
    end
    if (en_o) begin
      out_screen_x_r   <= plp_r.vis ? vsp_pkg::sat32(px_r >>> 16) : 32'sd0;
      out_screen_y_r   <= plp_r.vis ? vsp_pkg::sat32(-(py_r >>> 16)) : 32'sd0;
      out_inv_depth_r  <= plp_r.vis ? invp_r : 31'd0;
      out_view_depth_r <= plp_r.depth;
      out_visible_r    <= plp_r.vis;
      out_brightness_r <= plp_r.shade;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_screen_x   = out_screen_x_r;
  assign out_screen_y   = out_screen_y_r;
  assign out_inv_depth  = out_inv_depth_r;
  assign out_view_depth = out_view_depth_r;
  assign out_visible    = out_visible_r;
  assign out_brightness = out_brightness_r;

  a_cull_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_visible_r) |->
      (out_screen_x_r == 32'sd0 && out_screen_y_r == 32'sd0 && out_inv_depth_r == 31'd0))
    else $error("culled item with nonzero projection");

  a_near_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_visible_r && out_view_depth_r <= 32'sd2) |->
      (out_inv_depth_r == vsp_pkg::INV_MAX))
    else $error("small visible depth without saturated reciprocal");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule

FILE: hw/rtl/vsp_ram.sv
module vsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/vsp_xform.sv
module vsp_xform #(
  parameter int BONE_COUNT = vsp_pkg::BONE_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vsp_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_nrm_x,
  input  logic signed [31:0] in_nrm_y,
  input  logic signed [31:0] in_nrm_z,
  input  logic [4:0]         in_bone,
  input  logic [3:0]         in_matrix_word,
  input  logic signed [31:0] in_matrix_value,
  output logic               dn_valid,
  input  logic               dn_stall,
  output vsp_pkg::proj_t     dn_data
);

  localparam int AW = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;

  logic en1, en2, en3, en4, en5, en6, en7, en8;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic acc, ld_acc, bone_ok;

  assign en8 = !v8_r || !dn_stall;
  assign en7 = !v7_r || en8;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_stall = !en1;
  assign acc      = in_valid && en1;
  assign ld_acc   = acc && (in_operation == vsp_pkg::OP_LOAD);
  assign bone_ok  = int'(in_bone) < BONE_COUNT;

  logic [31:0] m_rd [vsp_pkg::MAT_WORDS];

  for (genvar w = 0; w < vsp_pkg::MAT_WORDS; w++) begin : g_word
    vsp_ram #(.WIDTH(32), .DEPTH(BONE_COUNT)) u_ram (
      .clk   (clk),
      .we    (ld_acc && bone_ok && (in_matrix_word == 4'(w))),
      .waddr (AW'(in_bone)),
      .wdata (in_matrix_value),
      .re    (en1),
      .raddr (AW'(in_bone)),
      .rdata (m_rd[w])
    );
  end

  logic signed [31:0] p1_r [3];
  logic signed [31:0] n1_r [3];
  logic               bok1_r;

  logic signed [31:0] mm [vsp_pkg::MAT_WORDS];
  logic signed [63:0] pmx [9];
  logic signed [63:0] nmx [9];
  logic signed [47:0] pm2_r [9];
  logic signed [47:0] nm2_r [9];
  logic signed [31:0] t2_r [3];
  logic signed [31:0] p2_r [3];
  logic signed [31:0] n2_r [3];

  always_comb begin
    for (int i = 0; i < vsp_pkg::MAT_WORDS; i++) begin
      mm[i] = bok1_r ? $signed(m_rd[i]) : 32'sd0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pmx[r*3+c] = 64'(mm[r*4+c]) * 64'(p1_r[c]);
        nmx[r*3+c] = 64'(mm[r*4+c]) * 64'(n1_r[c]);
      end
    end
  end

  logic signed [31:0] s3_r [3];
  logic signed [31:0] q3_r [3];
  logic signed [31:0] s3_nxt [3];
  logic signed [31:0] q3_nxt [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s3_nxt[r] = cfg.skin_en ? vsp_pkg::sat32(64'(pm2_r[r*3]) + 64'(pm2_r[r*3+1])
                                + 64'(pm2_r[r*3+2]) + 64'(t2_r[r])) : p2_r[r];
      q3_nxt[r] = cfg.skin_en ? vsp_pkg::sat32(64'(nm2_r[r*3]) + 64'(nm2_r[r*3+1])
                                + 64'(nm2_r[r*3+2])) : n2_r[r];
    end
  end

  logic signed [49:0] ra4, rb4, rc4, rd4;
  logic signed [49:0] l4 [3];
  logic signed [33:0] ra4_r, rb4_r, rc4_r, rd4_r;
  logic signed [33:0] l4_r [3];
  logic signed [31:0] sy4_r;

  assign ra4   = s3_r[0] * cfg.cos_yaw;
  assign rb4   = s3_r[2] * cfg.sin_yaw;
  assign rc4   = s3_r[2] * cfg.cos_yaw;
  assign rd4   = s3_r[0] * cfg.sin_yaw;
  assign l4[0] = q3_r[0] * vsp_pkg::LIGHT_LX;
  assign l4[1] = q3_r[1] * vsp_pkg::LIGHT_LY;
  assign l4[2] = q3_r[2] * vsp_pkg::LIGHT_LZ;

  logic signed [31:0] rx5_r, rz5_r, sy5_r;
  logic signed [35:0] dot5_r;

  logic signed [49:0] e6, f6, g6, h6;
  logic signed [63:0] rxf6;
  logic signed [53:0] lt6;
  logic signed [31:0] focal_s;
  logic signed [33:0] e6_r, f6_r, g6_r, h6_r;
  logic signed [47:0] rxf6_r;
  logic signed [37:0] lt6_r;

  assign focal_s = $signed({1'b0, cfg.focal});
  assign e6   = sy5_r * cfg.cos_pitch;
  assign f6   = rz5_r * cfg.sin_pitch;
  assign g6   = sy5_r * cfg.sin_pitch;
  assign h6   = rz5_r * cfg.cos_pitch;
  assign rxf6 = 64'(rx5_r) * 64'(focal_s);
  assign lt6  = dot5_r * vsp_pkg::LIGHT_GAIN;

  logic signed [31:0] ry7_r, dep7_r, rxs7_r;
  logic [7:0]         shade7_r;
  logic signed [38:0] lit7;
  logic signed [38:0] lsh7;
  logic [7:0]         shade7_nxt;

  always_comb begin
    lit7 = vsp_pkg::LIGHT_AMBIENT + (cfg.light_en ? 39'(lt6_r) : 39'sd0);
    lsh7 = lit7 >>> 9;
    shade7_nxt = (lsh7 > 39'sd255) ? 8'hff : lsh7[7:0];
  end

  logic signed [63:0] ryf8;
  vsp_pkg::proj_t     pl8_r;
  vsp_pkg::proj_t     pl8_nxt;

  assign ryf8 = 64'(ry7_r) * 64'(focal_s);

  always_comb begin
    pl8_nxt.rxs     = rxs7_r;
    pl8_nxt.rys     = vsp_pkg::sat32(ryf8 >>> 16);
    pl8_nxt.depth   = dep7_r;
    pl8_nxt.vis     = dep7_r >= $signed({1'b0, cfg.near_d});
    pl8_nxt.inv_sat = dep7_r <= 32'sd2;
    pl8_nxt.shade   = shade7_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      if (en1) v1_r <= acc && (in_operation == vsp_pkg::OP_VERTEX);
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
      if (en8) v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p1_r[0] <= in_pos_x;
      p1_r[1] <= in_pos_y;
      p1_r[2] <= in_pos_z;
      n1_r[0] <= in_nrm_x;
      n1_r[1] <= in_nrm_y;
      n1_r[2] <= in_nrm_z;
      bok1_r  <= bone_ok;
    end
    if (en2) begin
      for (int i = 0; i < 9; i++) begin
        pm2_r[i] <= pmx[i][63:16];
        nm2_r[i] <= nmx[i][63:16];
      end
      for (int r = 0; r < 3; r++) begin
        t2_r[r] <= mm[r*4+3];
        p2_r[r] <= p1_r[r];
        n2_r[r] <= n1_r[r];
      end
    end
    if (en3) begin
      s3_r <= s3_nxt;
      q3_r <= q3_nxt;
    end
    if (en4) begin
      ra4_r <= ra4[49:16];
      rb4_r <= rb4[49:16];
      rc4_r <= rc4[49:16];
      rd4_r <= rd4[49:16];
      for (int i = 0; i < 3; i++) begin
        l4_r[i] <= l4[i][49:16];
      end
      sy4_r <= s3_r[1];
    end
    if (en5) begin
      rx5_r  <= vsp_pkg::sat32(64'(ra4_r) + 64'(rb4_r));
      rz5_r  <= vsp_pkg::sat32(64'(rc4_r) - 64'(rd4_r));
      dot5_r <= 36'(l4_r[0]) + 36'(l4_r[1]) + 36'(l4_r[2]);
      sy5_r  <= sy4_r;
    end
    if (en6) begin
      e6_r   <= e6[49:16];
      f6_r   <= f6[49:16];
      g6_r   <= g6[49:16];
      h6_r   <= h6[49:16];
      rxf6_r <= rxf6[63:16];
      lt6_r  <= (dot5_r > 36'sd0) ? lt6[53:16] : 38'sd0;
    end
    if (en7) begin
      ry7_r    <= vsp_pkg::sat32(64'(e6_r) - 64'(f6_r));
      dep7_r   <= vsp_pkg::sat32(64'(g6_r) + 64'(h6_r));
      rxs7_r   <= vsp_pkg::sat32(64'(rxf6_r));
      shade7_r <= shade7_nxt;
    end
    if (en8) begin
      pl8_r <= pl8_nxt;
    end
  end

  assign dn_valid = v8_r;
  assign dn_data  = pl8_r;

  a_load_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_operation == vsp_pkg::OP_LOAD) |=> !v1_r)
    else $error("load item entered the vertex pipeline");

endmodule

FILE: hw/rtl/vsp_recip.sv
module vsp_recip (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_stall,
  input  vsp_pkg::proj_t up_data,
  output logic           dn_valid,
  input  logic           dn_stall,
  output vsp_pkg::proj_t dn_data,
  output logic [30:0]    dn_inv
);

  localparam int Steps = 31;

  logic           v_r  [Steps];
  logic [30:0]    r_r  [Steps];
  logic [30:0]    q_r  [Steps];
  vsp_pkg::proj_t pl_r [Steps];

  logic           en     [Steps];
  logic           v_in   [Steps];
  logic [30:0]    r_in   [Steps];
  logic [30:0]    q_in   [Steps];
  vsp_pkg::proj_t pl_in  [Steps];
  logic [30:0]    r_nxt  [Steps];
  logic [30:0]    q_nxt  [Steps];

  always_comb begin
    logic [31:0] t;
    logic [31:0] dd;
    logic        ge;
    t  = '0;
    dd = '0;
    ge = 1'b0;
    en[Steps-1] = !v_r[Steps-1] || !dn_stall;
    for (int k = Steps - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    for (int k = 0; k < Steps; k++) begin
      if (k == 0) begin
        v_in[k]  = up_valid;
        r_in[k]  = 31'd2;
        q_in[k]  = '0;
        pl_in[k] = up_data;
      end else begin
        v_in[k]  = v_r[k-1];
        r_in[k]  = r_r[k-1];
        q_in[k]  = q_r[k-1];
        pl_in[k] = pl_r[k-1];
      end
      t        = {r_in[k], 1'b0};
      dd       = {1'b0, pl_in[k].depth[30:0]};
      ge       = t >= dd;
      r_nxt[k] = ge ? 31'(t - dd) : t[30:0];
      q_nxt[k] = {q_in[k][29:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < Steps; k++) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < Steps; k++) begin
      if (en[k]) begin
        r_r[k]  <= r_nxt[k];
        q_r[k]  <= q_nxt[k];
        pl_r[k] <= pl_in[k];
      end
    end
  end

  assign up_stall = !en[0];
  assign dn_valid = v_r[Steps-1];
  assign dn_data  = pl_r[Steps-1];
  assign dn_inv   = pl_r[Steps-1].inv_sat ? vsp_pkg::INV_MAX : q_r[Steps-1];

endmodule
